FILE: rtl/core/multi_slot_software_timer_bank_defines.svh
// Assertion helpers used by the timer bank RTL.
`ifndef MULTI_SLOT_SOFTWARE_TIMER_BANK_DEFINES_SVH
`define MULTI_SLOT_SOFTWARE_TIMER_BANK_DEFINES_SVH

// same-cycle implication, checked out of reset
`define MSTB_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define MSTB_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/mstb_pkg.sv
package mstb_pkg;

  typedef enum logic [1:0] {
    MODE_TICK   = 2'd0,
    MODE_CREATE = 2'd1,
    MODE_DELETE = 2'd2,
    MODE_NONE   = 2'd3
  } tmr_mode_t;

  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_NO_SLOT  = 2'd1,
    STAT_BAD_SLOT = 2'd2
  } tmr_status_t;

  localparam int unsigned TickW   = 16;
  localparam int unsigned SlotW   = 4;
  localparam int unsigned IdxW    = 8;
  localparam int unsigned MaskW   = 16;
  localparam int unsigned LimitRst = 100;

  // command travelling down the row of slot cells
  typedef struct packed {
    logic               vld;
    tmr_mode_t          mode;
    logic [TickW-1:0]   tick;     // tick count after this beat
    logic [TickW-1:0]   expiry;   // expiry for a new slot
    logic [TickW-1:0]   period;   // period for a new slot, 0 for one-shot
    logic [IdxW-1:0]    del_idx;
    logic               bad;      // delete index out of range
    logic               claimed;
    logic [SlotW-1:0]   slot;
    logic [MaskW-1:0]   fired;
  } tok_t;

endpackage

FILE: rtl/core/multi_slot_software_timer_bank.sv
// An accepted beat is registered in the injection register, walks the row of
// NUM_SLOTS slot cells one cell per cycle and is latched into the output register.
// Only one command is in the row; the next beat is taken the cycle after a command
// leaves the row, unless its result must be parked because the output is stalled.
// A result may wait in the output register while the next beat walks; a second
// finished result is held aside and blocks the input until the output drains.
`include "multi_slot_software_timer_bank_defines.svh"

module multi_slot_software_timer_bank #(
  parameter int unsigned NUM_SLOTS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  // in_tdata: [15:0] timeout_ticks, [16] periodic_flag, [24:17] slot_index
  input  logic [31:0] in_tdata,
  // in_tuser: [1:0] mode
  input  logic [1:0]  in_tuser,
  input  logic        in_tvalid,
  output logic        in_tready,
  // out_tdata: [3:0] slot_out, [19:4] fired_mask
  output logic [23:0] out_tdata,
  // out_tuser: [1:0] status
  output logic [1:0]  out_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  input  logic [15:0] cfg_data,
  input  logic        cfg_valid,
  output logic        cfg_ready
);
  import mstb_pkg::*;

  logic [TickW-1:0] limit_r;
  logic [TickW-1:0] tick_r, tick_nxt;
  logic             busy_r, busy_nxt;
  tok_t             inj_r, inj_nxt;
  tok_t             chain_w [NUM_SLOTS+1];
  logic [NUM_SLOTS-1:0] chain_vld;
  tok_t             exit_w;
  tmr_status_t      exit_status;
  logic             out_free;
  logic             out_vld_r, out_vld_nxt;
  tmr_status_t      status_r, status_nxt;
  logic [SlotW-1:0] slot_r, slot_nxt;
  logic [MaskW-1:0] fired_r, fired_nxt;
  logic             pend_vld_r, pend_vld_nxt;
  tmr_status_t      pend_status_r, pend_status_nxt;
  logic [SlotW-1:0] pend_slot_r, pend_slot_nxt;
  logic [MaskW-1:0] pend_fired_r, pend_fired_nxt;

  logic             in_acc;
  tmr_mode_t        in_mode;
  logic [TickW-1:0] in_timeout;
  logic             in_periodic;
  logic [IdxW-1:0]  in_idx;
  logic [TickW-1:0] delay;

  assign cfg_ready   = 1'b1;
  assign in_mode     = tmr_mode_t'(in_tuser);
  assign in_timeout  = in_tdata[15:0];
  assign in_periodic = in_tdata[16];
  assign in_idx      = in_tdata[24:17];

  assign in_tready = !busy_r;
  assign in_acc    = in_tvalid && in_tready;
  assign out_free  = !out_vld_r || out_tready;

  // delay to first expiry; zero and short periodic timeouts collapse to one tick
  always_comb begin
    if (in_periodic && (in_timeout < limit_r)) begin
      delay = TickW'(1);
    end else if (in_timeout == '0) begin
      delay = TickW'(1);
    end else begin
      delay = in_timeout;
    end
  end

  always_comb begin
    tick_nxt = tick_r;
    inj_nxt  = '0;
    if (in_acc) begin
      inj_nxt.vld     = 1'b1;
      inj_nxt.mode    = in_mode;
      inj_nxt.tick    = tick_r + TickW'(1);
      inj_nxt.expiry  = tick_r + delay;
      inj_nxt.period  = in_periodic ? delay : '0;
      inj_nxt.del_idx = in_idx;
      inj_nxt.bad     = (in_mode == MODE_DELETE) && (in_idx >= IdxW'(NUM_SLOTS));
      if (in_mode == MODE_TICK) begin
        tick_nxt = tick_r + TickW'(1);
      end
    end
  end

  assign chain_w[0] = inj_r;

  for (genvar g = 0; g < NUM_SLOTS; g++) begin : g_cell
    mstb_cell #(
      .CELL_IDX(g)
    ) u_cell (
      .clk  (clk),
      .rst_n(rst_n),
      .tok_i(chain_w[g]),
      .tok_o(chain_w[g+1])
    );
    assign chain_vld[g] = chain_w[g+1].vld;
  end

  assign exit_w = chain_w[NUM_SLOTS];

  always_comb begin
    priority if ((exit_w.mode == MODE_CREATE) && !exit_w.claimed) begin
      exit_status = STAT_NO_SLOT;
    end else if (exit_w.bad) begin
      exit_status = STAT_BAD_SLOT;
    end else begin
      exit_status = STAT_OK;
    end
  end

  always_comb begin
    busy_nxt        = busy_r;
    out_vld_nxt     = out_vld_r;
    status_nxt      = status_r;
    slot_nxt        = slot_r;
    fired_nxt       = fired_r;
    pend_vld_nxt    = pend_vld_r;
    pend_status_nxt = pend_status_r;
    pend_slot_nxt   = pend_slot_r;
    pend_fired_nxt  = pend_fired_r;
    if (out_vld_r && out_tready) begin
      out_vld_nxt = 1'b0;
    end
    if (in_acc) begin
      busy_nxt = 1'b1;
    end
    if (pend_vld_r && out_free) begin
      busy_nxt     = 1'b0;
      pend_vld_nxt = 1'b0;
      out_vld_nxt  = 1'b1;
      status_nxt   = pend_status_r;
      slot_nxt     = pend_slot_r;
      fired_nxt    = pend_fired_r;
    end
    if (exit_w.vld) begin
      if (out_free) begin
        busy_nxt    = 1'b0;
        out_vld_nxt = 1'b1;
        status_nxt  = exit_status;
        slot_nxt    = exit_w.slot;
        fired_nxt   = exit_w.fired;
      end else begin
        // output still stalled: park the result, keep the input closed
        pend_vld_nxt    = 1'b1;
        pend_status_nxt = exit_status;
        pend_slot_nxt   = exit_w.slot;
        pend_fired_nxt  = exit_w.fired;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r    <= TickW'(LimitRst);
      tick_r     <= '0;
      busy_r     <= 1'b0;
      inj_r      <= '0;
      out_vld_r  <= 1'b0;
      pend_vld_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        limit_r <= cfg_data;
      end
      tick_r     <= tick_nxt;
      busy_r     <= busy_nxt;
      inj_r      <= inj_nxt;
      out_vld_r  <= out_vld_nxt;
      pend_vld_r <= pend_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    status_r      <= status_nxt;
    slot_r        <= slot_nxt;
    fired_r       <= fired_nxt;
    pend_status_r <= pend_status_nxt;
    pend_slot_r   <= pend_slot_nxt;
    pend_fired_r  <= pend_fired_nxt;
  end

  assign out_tvalid = out_vld_r;
  assign out_tuser  = status_r;
  assign out_tdata  = {4'd0, fired_r, slot_r};

  `MSTB_ASSERT_NEXT(a_acc_busy, clk, rst_n, in_acc, busy_r && inj_r.vld, "accept did not start a walk")
  `MSTB_ASSERT_NOW(a_one_cmd, clk, rst_n, 1'b1, $onehot0({chain_vld, inj_r.vld}), "more than one command in the row")
  `MSTB_ASSERT_NOW(a_exit_busy, clk, rst_n, exit_w.vld, busy_r && !pend_vld_r, "command left the row with nowhere to go")
  `MSTB_ASSERT_NEXT(a_exit_done, clk, rst_n, exit_w.vld, out_vld_r, "result not latched after walk")
  `MSTB_ASSERT_NOW(a_pend_stall, clk, rst_n, pend_vld_r, !in_tready, "input open while a result is parked")

endmodule

FILE: rtl/core/mstb_cell.sv
module mstb_cell #(
  parameter int unsigned CELL_IDX = 0
) (
  input  logic          clk,
  input  logic          rst_n,
  input  mstb_pkg::tok_t tok_i,
  output mstb_pkg::tok_t tok_o
);
  import mstb_pkg::*;

  localparam logic [MaskW-1:0] FIRE_BIT =
    (CELL_IDX < MaskW) ? (MaskW'(1) << CELL_IDX) : '0;

  logic             active_r, active_nxt;
  logic [TickW-1:0] expiry_r, expiry_nxt;
  logic [TickW-1:0] period_r, period_nxt;
  tok_t             tok_r, tok_nxt;

  always_comb begin
    active_nxt = active_r;
    expiry_nxt = expiry_r;
    period_nxt = period_r;
    tok_nxt    = tok_i;
    if (tok_i.vld) begin
      unique case (tok_i.mode)
        MODE_TICK: begin
          if (active_r && (expiry_r == tok_i.tick)) begin
            tok_nxt.fired = tok_i.fired | FIRE_BIT;
            if (period_r != '0) begin
              expiry_nxt = expiry_r + period_r;
            end else begin
              active_nxt = 1'b0;
            end
          end
        end
        MODE_CREATE: begin
          // first free cell along the row takes the request
          if (!tok_i.claimed && !active_r) begin
            active_nxt      = 1'b1;
            expiry_nxt      = tok_i.expiry;
            period_nxt      = tok_i.period;
            tok_nxt.claimed = 1'b1;
            tok_nxt.slot    = SlotW'(CELL_IDX);
          end
        end
        MODE_DELETE: begin
          if (tok_i.del_idx == IdxW'(CELL_IDX)) begin
            active_nxt = 1'b0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      tok_r    <= '0;
    end else begin
      active_r <= active_nxt;
      tok_r    <= tok_nxt;
    end
  end

  always_ff @(posedge clk) begin
    expiry_r <= expiry_nxt;
    period_r <= period_nxt;
  end

  assign tok_o = tok_r;

endmodule
